@@ rtl/crcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared constants, types and the CRC-8 step for the framed packet receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int BYTE_W = 8;
    localparam int TIME_W = 32;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;
    localparam int MAXP_W = 6;

    localparam logic [LEN_W-1:0]  HEAD_BYTES     = 7'd3;
    localparam logic [LEN_W-1:0]  OVERHEAD_BYTES = 7'd4;
    localparam logic [BYTE_W-1:0] CRC_POLY       = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_TOP        = 8'h80;

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd165;
    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 6'd60;
    localparam logic [BYTE_W-1:0] GAP_TIMEOUT_RST = 8'd10;

    typedef enum logic [1:0] {
        CFG_START_BYTE  = 2'd0,
        CFG_MAX_PAYLOAD = 2'd1,
        CFG_GAP_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_ERR  = 4'b1000
    } t_state;

    // One byte of CRC-8, MSB first.
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int b = 0; b < BYTE_W; b++) begin
            if ((c & CRC_TOP) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/crcfr_in_if.sv @@
// ----------------------------------------------------------------------------
// crcfr_in_if
// Receive byte channel: one received byte and its millisecond timestamp.
// ----------------------------------------------------------------------------
interface crcfr_in_if;
    import crcfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic [TIME_W-1:0] arrival_time;

    modport source (output valid, output rx_byte, output arrival_time, input ready);
    modport sink   (input valid, input rx_byte, input arrival_time, output ready);
endinterface

@@ rtl/crcfr_out_if.sv @@
// ----------------------------------------------------------------------------
// crcfr_out_if
// Frame channel: one byte of a checked frame, or a single CRC error beat.
// ----------------------------------------------------------------------------
interface crcfr_out_if;
    import crcfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic [LEN_W-1:0]  frame_length;
    logic              last_of_frame;
    logic              crc_mismatch;

    modport source (output valid, output frame_byte, output byte_position,
                    output frame_length, output last_of_frame, output crc_mismatch,
                    input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input frame_length, input last_of_frame, input crc_mismatch,
                    output ready);
endinterface

@@ rtl/crc8_framed_packet_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver_unit
// Assembles start/header/length/payload/CRC-8 frames from timestamped bytes.
// ----------------------------------------------------------------------------
// The input channel carries one received byte and its millisecond timestamp
// per beat. Bytes are written into a 64-entry frame store as they arrive, and
// the CRC-8 runs alongside, so a byte that does not end a frame leaves the
// block idle and ready for the next byte.
// When the CRC byte of a frame arrives and matches, the frame is read back
// from the store and sent on the output channel, one beat per byte, with
// last_of_frame on the final one. Each byte goes through a store read
// (ST_READ) and then an output register load (ST_LOAD), and the input is
// held off while the frame drains. A bad CRC gives a single error beat.
// The output has a register of its own: the input is taken again as soon as
// the final beat is loaded, even while that beat waits for the receiver.
// If the receiver stalls, readout waits on the output register and resumes
// when it is taken; no beat is lost or repeated.
// The configuration port takes start_byte, max_payload and gap_timeout; the
// user must write it only while the block is idle, which the block does not
// enforce. Synchronous reset returns them to 165, 60 and 10 and drops any
// partial frame; the store needs no clearing: only the current frame is read.
// ----------------------------------------------------------------------------
module crc8_framed_packet_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crcfr_in_if.sink    i_in,
    crcfr_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import crcfr_pkg::*;

    // Configuration registers.
    logic [BYTE_W-1:0] r_start_byte;
    logic [MAXP_W-1:0] r_max_payload;
    logic [BYTE_W-1:0] r_gap_timeout;

    // Frame state.
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]  r_exp, n_exp;
    logic [TIME_W-1:0] r_last, n_last;
    logic [BYTE_W-1:0] r_crc, n_crc;
    t_state            r_state, n_state;
    logic [STORE_AW-1:0] r_idx, n_idx;
    logic [LEN_W-1:0]  r_len, n_len;

    // Frame store.
    logic [BYTE_W-1:0]   r_store [STORE_DEPTH];
    logic [BYTE_W-1:0]   r_rd_data;
    logic                w_we;
    logic [STORE_AW-1:0] w_waddr;
    logic                w_rd;

    // Output register.
    logic              r_ov, n_ov;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic [POS_W-1:0]  r_opos, n_opos;
    logic [LEN_W-1:0]  r_olen, n_olen;
    logic              r_olast, n_olast;
    logic              r_omm, n_omm;

    logic              w_accept;
    logic              w_out_free;
    logic [TIME_W-1:0] w_delta;
    logic              w_timeout;
    logic [LEN_W-1:0]  w_fill;
    logic [LEN_W-1:0]  w_exp_in;
    logic [LEN_W-1:0]  w_nf;
    logic [LEN_W-1:0]  w_exp_new;
    logic [LEN_W-1:0]  w_idx_next;
    logic [BYTE_W-1:0] w_byte;

    assign i_in.ready          = (r_state == ST_IDLE);
    assign w_accept            = i_in.valid && i_in.ready;
    assign w_out_free          = !r_ov || o_out.ready;
    assign w_byte              = i_in.rx_byte;

    assign o_out.valid         = r_ov;
    assign o_out.frame_byte    = r_obyte;
    assign o_out.byte_position = r_opos;
    assign o_out.frame_length  = r_olen;
    assign o_out.last_of_frame = r_olast;
    assign o_out.crc_mismatch  = r_omm;

    // A partial frame is dropped when the gap since the previous byte is too long.
    assign w_delta    = i_in.arrival_time - r_last;
    assign w_timeout  = (r_fill != '0) && (w_delta > TIME_W'(r_gap_timeout));
    assign w_fill     = w_timeout ? '0 : r_fill;
    assign w_exp_in   = w_timeout ? '0 : r_exp;
    assign w_nf       = w_fill + LEN_W'(1);
    assign w_idx_next = LEN_W'(r_idx) + LEN_W'(1);

    always_comb begin
        n_fill    = r_fill;
        n_exp     = r_exp;
        n_last    = r_last;
        n_crc     = r_crc;
        n_state   = r_state;
        n_idx     = r_idx;
        n_len     = r_len;
        n_ov      = r_ov;
        n_obyte   = r_obyte;
        n_opos    = r_opos;
        n_olen    = r_olen;
        n_olast   = r_olast;
        n_omm     = r_omm;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_rd      = 1'b0;
        w_exp_new = w_exp_in;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_last = i_in.arrival_time;
                    n_fill = w_fill;
                    n_exp  = w_exp_in;
                    if (w_fill == '0 || (w_fill < HEAD_BYTES && w_byte == r_start_byte)) begin
                        // A start byte opens the frame, or reopens it early on.
                        if (w_byte == r_start_byte) begin
                            w_we   = 1'b1;
                            w_waddr = '0;
                            n_fill = LEN_W'(1);
                            n_exp  = '0;
                            n_crc  = crc8_update('0, w_byte);
                        end
                    end else if (w_fill >= LEN_W'(STORE_DEPTH)) begin
                        n_fill = '0;
                        n_exp  = '0;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_fill[STORE_AW-1:0];
                        if (w_nf == HEAD_BYTES && w_byte > BYTE_W'(r_max_payload)) begin
                            n_fill = '0;
                            n_exp  = '0;
                        end else begin
                            if (w_nf == HEAD_BYTES) begin
                                w_exp_new = LEN_W'(w_byte) + OVERHEAD_BYTES;
                            end
                            n_exp  = w_exp_new;
                            n_fill = w_nf;
                            n_crc  = crc8_update(r_crc, w_byte);
                            if (w_exp_new != '0 && w_nf == w_exp_new) begin
                                // The CRC byte has arrived: check it against the running CRC.
                                n_fill = '0;
                                n_exp  = '0;
                                n_len  = w_exp_new;
                                n_idx  = '0;
                                n_state = (r_crc != w_byte) ? ST_ERR : ST_READ;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                w_rd    = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_obyte = r_rd_data;
                    n_opos  = POS_W'(r_idx);
                    n_olen  = r_len;
                    n_olast = (w_idx_next == r_len);
                    n_omm   = 1'b0;
                    if (w_idx_next == r_len) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + STORE_AW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_ERR: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_obyte = '0;
                    n_opos  = '0;
                    n_olen  = '0;
                    n_olast = 1'b1;
                    n_omm   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
            r_gap_timeout <= GAP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_BYTE:  r_start_byte  <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[MAXP_W-1:0];
                CFG_GAP_TIMEOUT: r_gap_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_exp   <= '0;
            r_last  <= '0;
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_exp   <= n_exp;
            r_last  <= n_last;
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc   <= n_crc;
        r_idx   <= n_idx;
        r_len   <= n_len;
        r_obyte <= n_obyte;
        r_opos  <= n_opos;
        r_olen  <= n_olen;
        r_olast <= n_olast;
        r_omm   <= n_omm;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_byte;
        end
        if (w_rd) begin
            r_rd_data <= r_store[r_idx];
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(STORE_DEPTH))
        else $error("fill count beyond the frame store");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.crc_mismatch) |->
            (o_out.last_of_frame && o_out.frame_length == '0))
        else $error("CRC error beat is malformed");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_of_frame && !o_out.crc_mismatch) |->
            (LEN_W'(o_out.byte_position) + LEN_W'(1) == o_out.frame_length))
        else $error("final frame beat at the wrong position");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && w_out_free) |=> o_out.valid)
        else $error("loaded frame beat not presented");
`endif

endmodule

@@ tb/sv/crc8_framed_packet_receiver_unit_test.sv @@
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver_unit_test
// Self-checking bench for the CRC-8 framed packet receiver.
// ----------------------------------------------------------------------------
// Timestamped bytes are queued by the stimulus process and presented by a
// driver with random gaps. Every accepted byte runs through a frame assembler
// model that computes the beats the block must emit. A monitor compares each
// output beat with the oldest predicted one. The receiver side stalls in
// random bursts and once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module crc8_framed_packet_receiver_unit_test;
    import crcfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [TIME_W-1:0] stamp;
    } t_rx_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic              last;
        logic              bad_crc;
    } t_frame_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    crcfr_in_if  in_if ();
    crcfr_out_if out_if ();

    crc8_framed_packet_receiver_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Configuration copy used by the assembler model and the frame builder.
    logic [BYTE_W-1:0] cfg_start       = START_BYTE_RST;
    logic [MAXP_W-1:0] cfg_max_payload = MAX_PAYLOAD_RST;
    logic [BYTE_W-1:0] cfg_gap         = GAP_TIMEOUT_RST;

    // Frame assembler state.
    logic [BYTE_W-1:0] asm_store [STORE_DEPTH];
    int unsigned       asm_fill = 0;
    int unsigned       asm_len  = 0;
    logic [TIME_W-1:0] asm_last = '0;

    t_rx_item    rx_pending_q [$];
    t_frame_beat frame_beats_due [$];
    logic [TIME_W-1:0] tb_now = '0;

    int unsigned rx_queued   = 0;
    int unsigned rx_accepted = 0;
    int unsigned beats_seen  = 0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_gap      = 0;
    int unsigned sink_hold   = 0;
    bit          squeeze_done = 1'b0;
    bit          calm        = 1'b0;
    bit          in_taken    = 1'b0;
    bit          out_taken   = 1'b0;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ b[k];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic assemble_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] now);
        logic [BYTE_W-1:0] crc;
        t_frame_beat       e;
        if (asm_fill != 0 && (now - asm_last) > {24'd0, cfg_gap}) begin
            asm_fill = 0;
            asm_len  = 0;
        end
        asm_last = now;
        if (asm_fill == 0) begin
            if (b == cfg_start) begin
                asm_store[0] = b;
                asm_fill     = 1;
            end
        end else if (asm_fill < HEAD_BYTES && b == cfg_start) begin
            asm_store[0] = b;
            asm_fill     = 1;
            asm_len      = 0;
        end else if (asm_fill >= STORE_DEPTH) begin
            asm_fill = 0;
            asm_len  = 0;
        end else begin
            asm_store[asm_fill] = b;
            asm_fill++;
            if (asm_fill == HEAD_BYTES && asm_store[2] > cfg_max_payload) begin
                asm_fill = 0;
                asm_len  = 0;
            end else begin
                if (asm_fill == HEAD_BYTES) begin
                    asm_len = asm_store[2] + OVERHEAD_BYTES;
                end
                if (asm_len != 0 && asm_fill == asm_len) begin
                    crc = '0;
                    for (int i = 0; i < asm_len - 1; i++) begin
                        crc = crc8_next(crc, asm_store[i]);
                    end
                    if (crc != asm_store[asm_len-1]) begin
                        e = '{data: '0, pos: '0, len: '0, last: 1'b1, bad_crc: 1'b1};
                        frame_beats_due.push_back(e);
                    end else begin
                        for (int i = 0; i < asm_len; i++) begin
                            e.data    = asm_store[i];
                            e.pos     = i[POS_W-1:0];
                            e.len     = asm_len[LEN_W-1:0];
                            e.last    = (i + 1 == asm_len);
                            e.bad_crc = 1'b0;
                            frame_beats_due.push_back(e);
                        end
                    end
                    asm_fill = 0;
                    asm_len  = 0;
                end
            end
        end
    endtask

    // Input driver: a new byte goes out once the previous one was taken.
    always @(negedge i_clk) begin : rx_driver
        t_rx_item it;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_taken) begin
            // Hold the byte until the block takes it.
        end else if (rx_gap > 0) begin
            in_if.valid <= 1'b0;
            rx_gap--;
        end else if (rx_pending_q.size() > 0) begin
            it = rx_pending_q.pop_front();
            in_if.valid        <= 1'b1;
            in_if.rx_byte      <= it.data;
            in_if.arrival_time <= it.stamp;
            if (!calm && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(1, 11);
            end
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // Output side: random stall bursts, and one long hold-off while bytes
    // are still waiting to go in, so the block backs up onto its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (sink_hold > 0) begin
            out_if.ready <= 1'b0;
            sink_hold--;
        end else if (!squeeze_done && beats_seen >= 12 && rx_queued - rx_accepted >= 12) begin
            squeeze_done = 1'b1;
            sink_hold    = 300;
            out_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            out_if.ready <= 1'b0;
            sink_hold    = $urandom_range(0, 10);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : beat_monitor
        t_frame_beat got;
        t_frame_beat want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            in_taken  = i_rst_n && in_if.valid && in_if.ready;
            out_taken = i_rst_n && out_if.valid && out_if.ready;
            if (out_taken) begin
                beats_seen++;
                got = '{data: out_if.frame_byte, pos: out_if.byte_position,
                        len: out_if.frame_length, last: out_if.last_of_frame,
                        bad_crc: out_if.crc_mismatch};
                if (frame_beats_due.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected beat byte=%0h pos=%0d len=%0d last=%0b crc_err=%0b",
                        got.data, got.pos, got.len, got.last, got.bad_crc));
                end else begin
                    want = frame_beats_due.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf(
                            "beat byte=%0h/%0h pos=%0d/%0d len=%0d/%0d last=%0b/%0b crc_err=%0b/%0b",
                            got.data, want.data, got.pos, want.pos, got.len, want.len,
                            got.last, want.last, got.bad_crc, want.bad_crc));
                    end
                end
            end
            if (in_taken) begin
                rx_accepted++;
                assemble_byte(in_if.rx_byte, in_if.arrival_time);
            end
        end
    end

    task automatic push_rx(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] stamp);
        t_rx_item it;
        it.data  = b;
        it.stamp = stamp;
        rx_pending_q.push_back(it);
        rx_queued++;
    endtask

    // Queues a whole frame under the current settings. A fresh frame starts
    // after a silence longer than the timeout, which drops any partial one.
    // A negative step picks a random spacing within the timeout.
    task automatic push_frame(input logic [BYTE_W-1:0] hdr, input int plen, input bit bad,
                              input bit fresh, input int step);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        if (fresh) begin
            tb_now += cfg_gap + 1 + $urandom_range(0, 3);
        end
        if (hdr == cfg_start) begin
            hdr = ~hdr;
        end
        if (plen == cfg_start) begin
            plen = (plen > 0) ? plen - 1 : plen + 1;
        end
        crc = '0;
        for (int i = 0; i < plen + 3; i++) begin
            if (i == 0) begin
                b = cfg_start;
            end else if (i == 1) begin
                b = hdr;
            end else if (i == 2) begin
                b = plen[7:0];
            end else begin
                b = 8'($urandom);
            end
            if (i > 0) begin
                tb_now += (step < 0) ? $urandom_range(0, cfg_gap) : step;
            end
            crc = crc8_next(crc, b);
            push_rx(b, tb_now);
        end
        if (bad) begin
            crc ^= 8'h01 << $urandom_range(0, 7);
        end
        tb_now += (step < 0) ? $urandom_range(0, cfg_gap) : step;
        push_rx(crc, tb_now);
    endtask

    // Mostly well-formed frames, with bad CRCs, line noise, frames cut off
    // by silence or an oversized length, and restarts mixed in.
    task automatic random_traffic(input int budget);
        int unsigned goal;
        int          kind;
        int          cap;
        goal = rx_queued + budget;
        while (rx_queued < goal) begin
            kind = $urandom_range(0, 9);
            cap  = (cfg_max_payload < 6) ? cfg_max_payload : 6;
            if (kind <= 5) begin
                push_frame(8'($urandom), $urandom_range(0, cap), 1'b0, 1'b1, -1);
            end else if (kind == 6) begin
                push_frame(8'($urandom), $urandom_range(0, cap), 1'b1, 1'b1, -1);
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 3)) begin
                    tb_now += $urandom;
                    push_rx(8'($urandom), tb_now);
                end
            end else if (kind == 8) begin
                tb_now += cfg_gap + 1;
                push_rx(cfg_start, tb_now);
                push_rx(8'($urandom), tb_now);
                if ($urandom_range(0, 1) == 1) begin
                    push_rx(8'($urandom_range(cfg_max_payload + 1, 255)), tb_now);
                end
            end else begin
                tb_now += cfg_gap + 1;
                push_rx(cfg_start, tb_now);
                push_frame(8'($urandom), $urandom_range(0, cap), 1'b0, 1'b0, -1);
            end
        end
    endtask

    task automatic wait_quiet();
        do begin
            @(negedge i_clk);
        end while (rx_queued != rx_accepted || frame_beats_due.size() != 0);
        // Let a byte that ends no frame settle before touching the registers.
        repeat (12) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] sb, input logic [5:0] mp, input logic [7:0] gt);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_BYTE;
        i_cfg_data <= sb;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAX_PAYLOAD;
        i_cfg_data <= {2'b00, mp};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_GAP_TIMEOUT;
        i_cfg_data <= gt;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_start       = sb;
        cfg_max_payload = mp;
        cfg_gap         = gt;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_START_BYTE;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.rx_byte      = '0;
        in_if.arrival_time = '0;
        out_if.ready       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Noise while idle, then a frame with a bad CRC.
        tb_now = 32'd5;
        push_rx(8'h00, tb_now);
        tb_now += 3;
        push_rx(8'hFF, tb_now);
        push_frame(8'h02, 0, 1'b1, 1'b1, -1);
        // Start bytes in the header and in the length position restart the frame.
        tb_now += 40;
        push_rx(cfg_start, tb_now);
        push_rx(cfg_start, tb_now);
        push_rx(8'h11, tb_now);
        push_rx(cfg_start, tb_now);
        push_frame(8'h12, 1, 1'b0, 1'b0, -1);
        // Length one above the maximum.
        tb_now += 40;
        push_rx(cfg_start, tb_now);
        push_rx(8'h22, tb_now);
        push_rx(8'd61, tb_now);
        // Silence one past the timeout drops a partial frame.
        tb_now += 40;
        push_rx(cfg_start, tb_now);
        push_rx(8'h33, tb_now);
        tb_now += cfg_gap + 1;
        push_rx(cfg_start, tb_now);
        push_frame(8'h34, 0, 1'b0, 1'b0, cfg_gap);
        // Spacing exactly at the timeout, across the timestamp wrap.
        tb_now = 32'hFFFF_FFE8;
        push_frame(8'h44, 1, 1'b0, 1'b1, cfg_gap);
        wait_quiet();

        set_config(8'h00, 6'd1, 8'd0);
        @(posedge i_clk);
        random_traffic(4);
        wait_quiet();

        set_config(8'hFF, 6'd60, 8'd255);
        @(posedge i_clk);
        push_frame(8'hA0, 60, 1'b0, 1'b1, -1);
        random_traffic(4);
        wait_quiet();

        set_config(8'h5A, 6'd0, 8'd3);
        @(posedge i_clk);
        random_traffic(4);
        wait_quiet();

        calm = 1'b1;
        set_config(8'hC3, 6'd43, 8'd17);
        @(posedge i_clk);
        random_traffic(6);
        wait_quiet();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/crcfr_pkg.sv
rtl/crcfr_in_if.sv
rtl/crcfr_out_if.sv
rtl/crc8_framed_packet_receiver_unit.sv
tb/sv/crc8_framed_packet_receiver_unit_test.sv
